@@ src/cpst_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cpst_pkg
// Request/response types and action codes of the polyhedron separating axis test.
// -----------------------------------------------------------------------------
package cpst_pkg;

   localparam logic [2:0] ACT_CLEAR  = 3'd0;
   localparam logic [2:0] ACT_VERTEX = 3'd1;
   localparam logic [2:0] ACT_FACE   = 3'd2;
   localparam logic [2:0] ACT_EDGE   = 3'd3;
   localparam logic [2:0] ACT_TEST   = 3'd4;

   typedef struct packed {
      logic [2:0]         action;
      logic               body;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
   } req_type;

   typedef struct packed {
      logic intersect_res;
      logic overflow;
   } rsp_type;

endpackage

@@ src/convex_polyhedron_sat_test.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// convex_polyhedron_sat_test
// Separating axis test of two convex polyhedra held in on-chip stores.
// -----------------------------------------------------------------------------
// Load and clear requests are accepted one per cycle while no test is running.
// A test request runs on one shared 34x34 multiplier, which forms the cross product
// of each edge pair and the projection of each vertex on a face or edge axis.
// The block is busy for the whole test; the result sits in an output register.
// Synchronous active-high reset clears counts, overflow flag and control;
// store contents are undefined until loaded.
module convex_polyhedron_sat_test #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_FACES    = 64,
   parameter int MAX_EDGES    = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cpst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cpst_pkg::rsp_type rsp_data
);
   import cpst_pkg::*;

   localparam int VAW = $clog2(MAX_VERTICES);
   localparam int FAW = $clog2(MAX_FACES);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int VDEPTH = 2 * (2 ** VAW);
   localparam int FDEPTH = 2 * (2 ** FAW);
   localparam int EDEPTH = 2 * (2 ** EAW);
   localparam logic [VAW:0] VMAX = (VAW + 1)'(MAX_VERTICES);
   localparam logic [FAW:0] FMAX = (FAW + 1)'(MAX_FACES);
   localparam logic [EAW:0] EMAX = (EAW + 1)'(MAX_EDGES);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FRD   = 4'd1;
   localparam logic [3:0] S_FLD   = 4'd2;
   localparam logic [3:0] S_VRD   = 4'd3;
   localparam logic [3:0] S_VDIF  = 4'd4;
   localparam logic [3:0] S_VMUL  = 4'd5;
   localparam logic [3:0] S_VSGN  = 4'd6;
   localparam logic [3:0] S_SIDE  = 4'd7;
   localparam logic [3:0] S_E0RD  = 4'd8;
   localparam logic [3:0] S_E0LD  = 4'd9;
   localparam logic [3:0] S_E1RD  = 4'd10;
   localparam logic [3:0] S_E1LD  = 4'd11;
   localparam logic [3:0] S_XMUL  = 4'd12;
   localparam logic [3:0] S_XCHK  = 4'd13;

   localparam logic [2:0] LAST_STEP = 3'd6;

   function automatic logic signed [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
      sub33 = 33'(signed'({a[31], a})) - 33'(signed'({b[31], b}));
   endfunction

   // stores
   logic [95:0]  vmem [VDEPTH];
   logic [191:0] fmem [FDEPTH];
   logic [191:0] emem [EDEPTH];
   logic [95:0]  vdata_ff;
   logic [191:0] fdata_ff, edata_ff;

   logic [VAW:0] vcnt_ff [2];
   logic [FAW:0] fcnt_ff [2];
   logic [EAW:0] ecnt_ff [2];
   logic         ovf_ff;

   logic [3:0]   state_ff, state_in;
   logic         own_ff, own_in;
   logic         sb_ff, sb_in;
   logic         edge_ph_ff, edge_ph_in;
   logic [FAW:0] fi_ff, fi_in;
   logic [VAW:0] vj_ff, vj_in;
   logic [EAW:0] i0_ff, i0_in, i1_ff, i1_in;
   logic         pos_ff, pos_in, neg_ff, neg_in, s0pos_ff, s0pos_in;
   logic [2:0]   step_ff, step_in;

   logic [31:0]         p_ff [3];
   logic [31:0]         p_in [3];
   logic signed [66:0]  n_ff [3];
   logic signed [66:0]  n_in [3];
   logic signed [32:0]  dv_ff [3];
   logic signed [32:0]  dv_in [3];
   logic signed [32:0]  d0_ff [3];
   logic signed [32:0]  d0_in [3];
   logic signed [32:0]  d1_ff [3];
   logic signed [32:0]  d1_in [3];
   logic signed [103:0] acc_ff, acc_in;
   logic signed [67:0]  prod_ff;
   logic                psub_ff, psh_ff;

   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic                accept, fin, fin_res;
   logic signed [33:0]  mul_a, mul_b;
   logic                msub, msh;
   logic signed [103:0] pext, acc_sum;
   logic                acc_zero;
   logic [VAW:0]        vaddr_idx;
   logic [VAW:0]        vaddr;
   logic [FAW:0]        faddr;
   logic [EAW:0]        eaddr;
   logic [1:0]          comp;

   assign req_stall = (state_ff != S_IDLE) ||
                      (req_data.action == ACT_TEST && rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // memory ports
   assign vaddr_idx = vj_ff;
   assign vaddr = {sb_ff, vaddr_idx[VAW-1:0]};
   assign faddr = {own_ff, fi_ff[FAW-1:0]};
   assign eaddr = (state_ff == S_E0RD) ? {1'b0, i0_ff[EAW-1:0]} : {1'b1, i1_ff[EAW-1:0]};

   always_ff @(posedge clock) begin
      if (accept && req_data.action == ACT_VERTEX && vcnt_ff[req_data.body] < VMAX) begin
         vmem[{req_data.body, vcnt_ff[req_data.body][VAW-1:0]}] <=
            {req_data.az, req_data.ay, req_data.ax};
      end
      vdata_ff <= vmem[vaddr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.action == ACT_FACE && fcnt_ff[req_data.body] < FMAX) begin
         fmem[{req_data.body, fcnt_ff[req_data.body][FAW-1:0]}] <=
            {req_data.bz, req_data.by, req_data.bx, req_data.az, req_data.ay, req_data.ax};
      end
      fdata_ff <= fmem[faddr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.action == ACT_EDGE && ecnt_ff[req_data.body] < EMAX) begin
         emem[{req_data.body, ecnt_ff[req_data.body][EAW-1:0]}] <=
            {req_data.bz, req_data.by, req_data.bx, req_data.az, req_data.ay, req_data.ax};
      end
      edata_ff <= emem[eaddr];
   end

   // counts
   always_ff @(posedge clock) begin
      if (reset) begin
         vcnt_ff[0] <= '0; vcnt_ff[1] <= '0;
         fcnt_ff[0] <= '0; fcnt_ff[1] <= '0;
         ecnt_ff[0] <= '0; ecnt_ff[1] <= '0;
         ovf_ff     <= 1'b0;
      end else if (accept) begin
         unique case (req_data.action)
            ACT_CLEAR: begin
               vcnt_ff[0] <= '0; vcnt_ff[1] <= '0;
               fcnt_ff[0] <= '0; fcnt_ff[1] <= '0;
               ecnt_ff[0] <= '0; ecnt_ff[1] <= '0;
               ovf_ff     <= 1'b0;
            end
            ACT_VERTEX: begin
               if (vcnt_ff[req_data.body] < VMAX) begin
                  vcnt_ff[req_data.body] <= vcnt_ff[req_data.body] + 1'b1;
               end else begin
                  ovf_ff <= 1'b1;
               end
            end
            ACT_FACE: begin
               if (fcnt_ff[req_data.body] < FMAX) begin
                  fcnt_ff[req_data.body] <= fcnt_ff[req_data.body] + 1'b1;
               end else begin
                  ovf_ff <= 1'b1;
               end
            end
            ACT_EDGE: begin
               if (ecnt_ff[req_data.body] < EMAX) begin
                  ecnt_ff[req_data.body] <= ecnt_ff[req_data.body] + 1'b1;
               end else begin
                  ovf_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      msub  = 1'b0;
      msh   = 1'b0;
      comp  = step_ff[2:1];
      if (state_ff == S_VMUL) begin
         msh = step_ff[0];
         unique case (comp)
            2'd0: mul_b = 34'(dv_ff[0]);
            2'd1: mul_b = 34'(dv_ff[1]);
            default: mul_b = 34'(dv_ff[2]);
         endcase
         unique case (comp)
            2'd0: mul_a = step_ff[0] ? n_ff[0][66:33] : {1'b0, n_ff[0][32:0]};
            2'd1: mul_a = step_ff[0] ? n_ff[1][66:33] : {1'b0, n_ff[1][32:0]};
            default: mul_a = step_ff[0] ? n_ff[2][66:33] : {1'b0, n_ff[2][32:0]};
         endcase
      end else begin
         msub = step_ff[0];
         unique case (step_ff)
            3'd0: begin mul_a = 34'(d0_ff[1]); mul_b = 34'(d1_ff[2]); end
            3'd1: begin mul_a = 34'(d0_ff[2]); mul_b = 34'(d1_ff[1]); end
            3'd2: begin mul_a = 34'(d0_ff[2]); mul_b = 34'(d1_ff[0]); end
            3'd3: begin mul_a = 34'(d0_ff[0]); mul_b = 34'(d1_ff[2]); end
            3'd4: begin mul_a = 34'(d0_ff[0]); mul_b = 34'(d1_ff[1]); end
            default: begin mul_a = 34'(d0_ff[1]); mul_b = 34'(d1_ff[0]); end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      psub_ff <= msub;
      psh_ff  <= msh;
   end

   assign pext     = psh_ff ? (104'(prod_ff) <<< 33) : 104'(prod_ff);
   assign acc_sum  = psub_ff ? (acc_ff - pext) : (acc_ff + pext);
   assign acc_zero = (acc_ff == '0);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      own_in     = own_ff;
      sb_in      = sb_ff;
      edge_ph_in = edge_ph_ff;
      fi_in      = fi_ff;
      vj_in      = vj_ff;
      i0_in      = i0_ff;
      i1_in      = i1_ff;
      pos_in     = pos_ff;
      neg_in     = neg_ff;
      s0pos_in   = s0pos_ff;
      step_in    = step_ff;
      acc_in     = acc_ff;
      p_in       = p_ff;
      n_in       = n_ff;
      dv_in      = dv_ff;
      d0_in      = d0_ff;
      d1_in      = d1_ff;
      fin        = 1'b0;
      fin_res    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.action == ACT_TEST) begin
               if (fcnt_ff[0] == '0 || fcnt_ff[1] == '0) begin
                  fin = 1'b1;
               end else begin
                  own_in     = 1'b0;
                  fi_in      = '0;
                  edge_ph_in = 1'b0;
                  state_in   = S_FRD;
               end
            end
         end
         S_FRD: begin
            if (fi_ff == fcnt_ff[own_ff]) begin
               if (!own_ff) begin
                  own_in = 1'b1;
                  fi_in  = '0;
               end else begin
                  edge_ph_in = 1'b1;
                  i0_in      = '0;
                  state_in   = S_E0RD;
               end
            end else begin
               state_in = S_FLD;
            end
         end
         S_FLD: begin
            for (int k = 0; k < 3; k++) begin
               p_in[k] = fdata_ff[32*k +: 32];
               n_in[k] = 67'(signed'(fdata_ff[96 + 32*k +: 32]));
            end
            sb_in    = ~own_ff;
            vj_in    = '0;
            pos_in   = 1'b0;
            neg_in   = 1'b0;
            state_in = S_VRD;
         end
         S_VRD: begin
            state_in = (vj_ff == vcnt_ff[sb_ff]) ? S_SIDE : S_VDIF;
         end
         S_VDIF: begin
            for (int k = 0; k < 3; k++) begin
               dv_in[k] = sub33(vdata_ff[32*k +: 32], p_ff[k]);
            end
            step_in  = '0;
            acc_in   = '0;
            state_in = S_VMUL;
         end
         S_VMUL: begin
            if (step_ff != '0) begin
               acc_in = acc_sum;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_VSGN;
            end
         end
         S_VSGN: begin
            if (acc_ff[103]) begin
               neg_in = 1'b1;
            end else if (!acc_zero) begin
               pos_in = 1'b1;
            end
            vj_in    = vj_ff + 1'b1;
            state_in = S_VRD;
         end
         S_SIDE: begin
            if (!edge_ph_ff) begin
               if (pos_ff && !neg_ff) begin
                  fin      = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  fi_in    = fi_ff + 1'b1;
                  state_in = S_FRD;
               end
            end else if (pos_ff && neg_ff) begin
               i1_in    = i1_ff + 1'b1;
               state_in = S_E1RD;
            end else if (!sb_ff) begin
               s0pos_in = pos_ff;
               sb_in    = 1'b1;
               vj_in    = '0;
               pos_in   = 1'b0;
               neg_in   = 1'b0;
               state_in = S_VRD;
            end else if (pos_ff != s0pos_ff) begin
               fin      = 1'b1;
               state_in = S_IDLE;
            end else begin
               i1_in    = i1_ff + 1'b1;
               state_in = S_E1RD;
            end
         end
         S_E0RD: begin
            if (i0_ff == ecnt_ff[0]) begin
               fin      = 1'b1;
               fin_res  = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_E0LD;
            end
         end
         S_E0LD: begin
            for (int k = 0; k < 3; k++) begin
               p_in[k]  = edata_ff[32*k +: 32];
               d0_in[k] = sub33(edata_ff[96 + 32*k +: 32], edata_ff[32*k +: 32]);
            end
            i1_in    = '0;
            state_in = S_E1RD;
         end
         S_E1RD: begin
            if (i1_ff == ecnt_ff[1]) begin
               i0_in    = i0_ff + 1'b1;
               state_in = S_E0RD;
            end else begin
               state_in = S_E1LD;
            end
         end
         S_E1LD: begin
            for (int k = 0; k < 3; k++) begin
               d1_in[k] = sub33(edata_ff[96 + 32*k +: 32], edata_ff[32*k +: 32]);
            end
            step_in  = '0;
            acc_in   = '0;
            state_in = S_XMUL;
         end
         S_XMUL: begin
            if (step_ff != '0) begin
               if (!step_ff[0]) begin
                  unique case (step_ff[2:1])
                     2'd1: n_in[0] = acc_sum[66:0];
                     2'd2: n_in[1] = acc_sum[66:0];
                     default: n_in[2] = acc_sum[66:0];
                  endcase
                  acc_in = '0;
               end else begin
                  acc_in = acc_sum;
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_XCHK;
            end
         end
         S_XCHK: begin
            if (n_ff[0] == '0 && n_ff[1] == '0 && n_ff[2] == '0) begin
               i1_in    = i1_ff + 1'b1;
               state_in = S_E1RD;
            end else begin
               sb_in    = 1'b0;
               vj_in    = '0;
               pos_in   = 1'b0;
               neg_in   = 1'b0;
               state_in = S_VRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      own_ff     <= own_in;
      sb_ff      <= sb_in;
      edge_ph_ff <= edge_ph_in;
      fi_ff      <= fi_in;
      vj_ff      <= vj_in;
      i0_ff      <= i0_in;
      i1_ff      <= i1_in;
      pos_ff     <= pos_in;
      neg_ff     <= neg_in;
      s0pos_ff   <= s0pos_in;
      step_ff    <= step_in;
      acc_ff     <= acc_in;
      p_ff       <= p_in;
      n_ff       <= n_in;
      dv_ff      <= dv_in;
      d0_ff      <= d0_in;
      d1_ff      <= d1_in;
      if (fin) begin
         rsp_ff.intersect_res <= fin_res;
         rsp_ff.overflow      <= ovf_ff;
      end
   end

endmodule

@@ tb/sv/cpst_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cpst_checker
// Watches both channels of the polyhedron separating axis test, keeps its own
// copy of the vertex, face and edge stores, works out the expected intersect
// and overflow flags of every test request in exact 128-bit arithmetic and
// compares them with the responses in order.
// -----------------------------------------------------------------------------
module cpst_checker #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_FACES    = 64,
   parameter int MAX_EDGES    = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  cpst_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  cpst_pkg::rsp_type rsp_data,
   output int                errors,
   output int                pending
);
   import cpst_pkg::*;

   typedef logic signed [127:0] wide_type;

   logic signed [31:0] vtx  [2][MAX_VERTICES][3];
   logic signed [31:0] fce  [2][MAX_FACES][6];
   logic signed [31:0] edg  [2][MAX_EDGES][6];
   int                 vcnt [2];
   int                 fcnt [2];
   int                 ecnt [2];
   bit                 ovf;
   rsp_type            expect_q[$];

   function automatic int body_side(int b, wide_type px, wide_type py, wide_type pz,
                                    wide_type nx, wide_type ny, wide_type nz);
      bit       pos;
      bit       neg;
      wide_type t;
      wide_type vx;
      wide_type vy;
      wide_type vz;
      pos = 0;
      neg = 0;
      for (int i = 0; i < vcnt[b]; i++) begin
         vx = vtx[b][i][0];
         vy = vtx[b][i][1];
         vz = vtx[b][i][2];
         t = nx * (vx - px) + ny * (vy - py) + nz * (vz - pz);
         if (t > 0) pos = 1;
         else if (t < 0) neg = 1;
      end
      if (pos && neg) return 0;
      return pos ? 1 : -1;
   endfunction

   function automatic bit bodies_overlap();
      wide_type p[3];
      wide_type n[3];
      wide_type d0[3];
      wide_type d1[3];
      int       s0;
      int       s1;
      if (fcnt[0] == 0 || fcnt[1] == 0) return 0;
      for (int own = 0; own < 2; own++) begin
         for (int i = 0; i < fcnt[own]; i++) begin
            for (int k = 0; k < 3; k++) begin
               p[k] = fce[own][i][k];
               n[k] = fce[own][i][k+3];
            end
            if (body_side(own ^ 1, p[0], p[1], p[2], n[0], n[1], n[2]) > 0) return 0;
         end
      end
      for (int i0 = 0; i0 < ecnt[0]; i0++) begin
         for (int k = 0; k < 3; k++) begin
            p[k]  = edg[0][i0][k];
            d0[k] = wide_type'(edg[0][i0][k+3]) - p[k];
         end
         for (int i1 = 0; i1 < ecnt[1]; i1++) begin
            for (int k = 0; k < 3; k++)
               d1[k] = wide_type'(edg[1][i1][k+3]) - wide_type'(edg[1][i1][k]);
            n[0] = d0[1] * d1[2] - d0[2] * d1[1];
            n[1] = d0[2] * d1[0] - d0[0] * d1[2];
            n[2] = d0[0] * d1[1] - d0[1] * d1[0];
            if (n[0] == 0 && n[1] == 0 && n[2] == 0) continue;
            s0 = body_side(0, p[0], p[1], p[2], n[0], n[1], n[2]);
            if (s0 == 0) continue;
            s1 = body_side(1, p[0], p[1], p[2], n[0], n[1], n[2]);
            if (s1 == 0) continue;
            if (s0 != s1) return 0;
         end
      end
      return 1;
   endfunction

   task automatic report(string what, logic e, logic a);
      errors++;
      if (errors <= 10)
         $display("%0t: %s expected %0b got %0b", $realtime, what, e, a);
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp;
      rsp_type got;
      int      b;
      if (reset) begin
         vcnt   = '{0, 0};
         fcnt   = '{0, 0};
         ecnt   = '{0, 0};
         ovf    = 0;
         errors = 0;
         expect_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expect_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("%0t: response with no test pending", $realtime);
            end else begin
               exp_rsp = expect_q.pop_front();
               if (got.intersect_res !== exp_rsp.intersect_res)
                  report("intersect_res", exp_rsp.intersect_res, got.intersect_res);
               if (got.overflow !== exp_rsp.overflow)
                  report("overflow", exp_rsp.overflow, got.overflow);
            end
         end
         if (req_valid && !req_stall) begin
            b = int'(req_data.body);
            case (req_data.action)
               ACT_CLEAR: begin
                  vcnt = '{0, 0};
                  fcnt = '{0, 0};
                  ecnt = '{0, 0};
                  ovf  = 0;
               end
               ACT_VERTEX: begin
                  if (vcnt[b] < MAX_VERTICES) begin
                     vtx[b][vcnt[b]] = '{req_data.ax, req_data.ay, req_data.az};
                     vcnt[b]++;
                  end else ovf = 1;
               end
               ACT_FACE: begin
                  if (fcnt[b] < MAX_FACES) begin
                     fce[b][fcnt[b]] = '{req_data.ax, req_data.ay, req_data.az,
                                         req_data.bx, req_data.by, req_data.bz};
                     fcnt[b]++;
                  end else ovf = 1;
               end
               ACT_EDGE: begin
                  if (ecnt[b] < MAX_EDGES) begin
                     edg[b][ecnt[b]] = '{req_data.ax, req_data.ay, req_data.az,
                                         req_data.bx, req_data.by, req_data.bz};
                     ecnt[b]++;
                  end else ovf = 1;
               end
               ACT_TEST: begin
                  exp_rsp.intersect_res = bodies_overlap();
                  exp_rsp.overflow      = ovf;
                  expect_q.push_back(exp_rsp);
               end
               default: ;
            endcase
         end
      end
      pending = expect_q.size();
   end

endmodule

@@ tb/sv/tb_convex_polyhedron_sat_test.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_convex_polyhedron_sat_test
// Drives the separating axis test with directed corner requests, store
// overflow fills and random pairs of tetrahedra mixed with noise, under
// several sender and receiver idling phases and one long receiver hold-off.
// -----------------------------------------------------------------------------
module tb_convex_polyhedron_sat_test;
   import cpst_pkg::*;

   localparam int MAX_V      = 64;
   localparam int MAX_F      = 64;
   localparam int MAX_E      = 128;
   localparam int WDOG_LIMIT = 100000;
   localparam int N_ITEMS    = 1250;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      errors;
   int      pending;

   int      idle_pct;
   int      stall_pct;
   bit      hold_on;
   int      sent;
   int      tests;
   int      fills;

   convex_polyhedron_sat_test #(
      .MAX_VERTICES(MAX_V), .MAX_FACES(MAX_F), .MAX_EDGES(MAX_E)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   cpst_checker #(
      .MAX_VERTICES(MAX_V), .MAX_FACES(MAX_F), .MAX_EDGES(MAX_E)
   ) chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         rsp_stall = hold_on || ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet = 0;
         else quiet++;
      end
      $display("convex_polyhedron_sat_test: mismatch");
      $finish;
   end

   function automatic req_type mk(logic [2:0] act, logic b,
                                  int ax, int ay, int az, int bx, int by, int bz);
      req_type r;
      r.action = act;
      r.body   = b;
      r.ax = ax; r.ay = ay; r.az = az;
      r.bx = bx; r.by = by; r.bz = bz;
      return r;
   endfunction

   function automatic req_type noise();
      return mk(3'($urandom_range(7)), 1'($urandom), $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
   endfunction

   task automatic push_req(req_type r);
      @(negedge clock);
      req_valid = 0;
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_data  = r;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      sent++;
      if (r.action == ACT_TEST) tests++;
   endtask

   // fill one store of one body past its capacity; the other body has no faces
   task automatic fill_store(logic [2:0] act, logic b);
      int cap;
      cap = (act == ACT_VERTEX) ? MAX_V : (act == ACT_FACE) ? MAX_F : MAX_E;
      push_req(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      repeat (cap + 1)
         push_req(mk(act, b, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      push_req(mk(ACT_TEST, 0, 0, 0, 0, 0, 0, 0));
      fills++;
   endtask

   // clear, load two random tetrahedra, test; some loads replaced by noise
   task automatic tetra_scene();
      int     v[4][3];
      int     c[3];
      int     fi[4][4];
      int     ei[6][2];
      longint e1[3];
      longint e2[3];
      longint nrm[3];
      longint dd;
      bit     broken;
      req_type r;
      fi = '{'{0, 1, 2, 3}, '{0, 1, 3, 2}, '{0, 2, 3, 1}, '{1, 2, 3, 0}};
      ei = '{'{0, 1}, '{0, 2}, '{0, 3}, '{1, 2}, '{1, 3}, '{2, 3}};
      broken = ($urandom_range(99) < 25);
      push_req(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      for (int b = 0; b < 2; b++) begin
         for (int k = 0; k < 3; k++) c[k] = int'($urandom_range(12000)) - 6000;
         for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++) v[i][k] = c[k] + int'($urandom_range(8000)) - 4000;
         for (int i = 0; i < 4; i++) begin
            r = mk(ACT_VERTEX, 1'(b), v[i][0], v[i][1], v[i][2], $urandom, $urandom,
                   $urandom);
            if (broken && $urandom_range(9) == 0) r = noise();
            push_req(r);
         end
         for (int f = 0; f < 4; f++) begin
            for (int k = 0; k < 3; k++) begin
               e1[k] = v[fi[f][1]][k] - v[fi[f][0]][k];
               e2[k] = v[fi[f][2]][k] - v[fi[f][0]][k];
            end
            nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
            nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
            nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
            dd = 0;
            for (int k = 0; k < 3; k++) dd += nrm[k] * (v[fi[f][3]][k] - v[fi[f][0]][k]);
            if (dd > 0) for (int k = 0; k < 3; k++) nrm[k] = -nrm[k];
            r = mk(ACT_FACE, 1'(b), v[fi[f][0]][0], v[fi[f][0]][1], v[fi[f][0]][2],
                   int'(nrm[0]), int'(nrm[1]), int'(nrm[2]));
            if (broken && $urandom_range(9) == 0) r = noise();
            push_req(r);
         end
         for (int e = 0; e < 6; e++) begin
            r = mk(ACT_EDGE, 1'(b), v[ei[e][0]][0], v[ei[e][0]][1], v[ei[e][0]][2],
                   v[ei[e][1]][0], v[ei[e][1]][1], v[ei[e][1]][2]);
            if (broken && $urandom_range(9) == 0) r = noise();
            push_req(r);
         end
      end
      push_req(mk(ACT_TEST, 1'($urandom), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom));
   endtask

   task automatic run_phase(int idle, int stall, int target, bit with_hold);
      idle_pct  = idle;
      stall_pct = stall;
      if (with_hold)
         fork
            begin
               repeat (300) @(negedge clock);
               hold_on = 1;
               repeat (4000) @(negedge clock);
               hold_on = 0;
            end
         join_none
      while (sent < target) begin
         if ($urandom_range(99) < 2)
            fill_store(3'($urandom_range(ACT_EDGE, ACT_VERTEX)), 1'($urandom));
         else
            tetra_scene();
      end
   endtask

   initial begin
      int maxi;
      int mini;
      maxi      = 32'h7fffffff;
      mini      = 32'h80000000;
      req_valid = 0;
      req_data  = '0;
      idle_pct  = 0;
      stall_pct = 0;
      hold_on   = 0;
      sent      = 0;
      tests     = 0;
      fills     = 0;
      reset     = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // corners: empty bodies, extreme coordinates, zero-length edge, unused actions
      push_req(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      push_req(mk(ACT_TEST, 0, 0, 0, 0, 0, 0, 0));
      push_req(mk(ACT_VERTEX, 0, maxi, maxi, maxi, 0, 0, 0));
      push_req(mk(ACT_VERTEX, 1, mini, mini, mini, 0, 0, 0));
      push_req(mk(ACT_FACE, 0, mini, mini, mini, maxi, maxi, maxi));
      push_req(mk(ACT_TEST, 0, 0, 0, 0, 0, 0, 0));
      push_req(mk(ACT_FACE, 1, maxi, maxi, maxi, mini, mini, mini));
      push_req(mk(ACT_TEST, 0, 0, 0, 0, 0, 0, 0));
      push_req(mk(ACT_EDGE, 0, 5, 5, 5, 5, 5, 5));
      push_req(mk(ACT_EDGE, 1, mini, maxi, mini, maxi, mini, maxi));
      push_req(mk(ACT_TEST, 1, 0, 0, 0, 0, 0, 0));
      push_req(mk(3'd5, 0, maxi, maxi, maxi, maxi, maxi, maxi));
      push_req(mk(3'd6, 1, mini, mini, mini, mini, mini, mini));
      push_req(mk(3'd7, 1, -1, -1, -1, -1, -1, -1));
      push_req(mk(ACT_EDGE, 0, maxi, mini, 0, mini, maxi, -1));
      push_req(mk(ACT_VERTEX, 0, 0, 0, 0, 0, 0, 0));
      push_req(mk(ACT_TEST, 0, 0, 0, 0, 0, 0, 0));
      push_req(mk(ACT_CLEAR, 1, maxi, maxi, maxi, maxi, maxi, maxi));
      push_req(mk(ACT_TEST, 0, 0, 0, 0, 0, 0, 0));

      fill_store(ACT_VERTEX, 0);
      fill_store(ACT_FACE, 1);
      fill_store(ACT_EDGE, 0);

      run_phase(0, 0, 450, 1);
      run_phase(79, 0, 700, 0);
      run_phase(0, 79, 950, 0);
      run_phase(26, 26, N_ITEMS, 0);

      @(negedge clock);
      req_valid = 0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("%0d requests sent, %0d tests, %0d overflow fills, over four idling phases",
               sent, tests, fills);
      if (errors == 0)
         $display("convex_polyhedron_sat_test: match");
      else
         $display("convex_polyhedron_sat_test: mismatch");
      $finish;
   end

endmodule
